### design/status_color_bar_animator_assert.svh
// Assertion macros used by the checker file.
`ifndef STATUS_COLOR_BAR_ANIMATOR_ASSERT_SVH
`define STATUS_COLOR_BAR_ANIMATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define SCBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define SCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/scba_pkg.sv
`timescale 1ns / 1ps

package scba_pkg;

  // Opcodes of an input item
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_SET  = 3'd1;
  localparam logic [2:0] OP_ACK  = 3'd2;
  localparam logic [2:0] OP_HIDE = 3'd3;
  localparam logic [2:0] OP_SHOW = 3'd4;

  // Status codes
  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_NOTIFY = 2'd1;
  localparam logic [1:0] ST_ALERT  = 2'd2;
  localparam logic [1:0] ST_SLEEP  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_BLINK_TICKS  = 3'd0;
  localparam logic [2:0] CFG_BREATH_TICKS = 3'd1;
  localparam logic [2:0] CFG_NORMAL_COLOR = 3'd2;
  localparam logic [2:0] CFG_NOTIFY_COLOR = 3'd3;
  localparam logic [2:0] CFG_ALERT_COLOR  = 3'd4;

  // Register reset values
  localparam logic [15:0] BLINK_TICKS_RST  = 16'd250;
  localparam logic [15:0] BREATH_TICKS_RST = 16'd20;
  localparam logic [15:0] NORMAL_COLOR_RST = 16'd1838;
  localparam logic [15:0] NOTIFY_COLOR_RST = 16'd11231;
  localparam logic [15:0] ALERT_COLOR_RST  = 16'd63656;

  // Breathing and blinking constants
  localparam logic [7:0] OPA_LOW      = 8'd30;
  localparam logic [7:0] OPA_HIGH     = 8'd255;
  localparam logic [7:0] OPA_STEP     = 8'd5;
  localparam logic [2:0] BLINK_PHASES = 3'd6;

  typedef struct packed {
    logic [15:0] blink_ticks;
    logic [15:0] breath_ticks;
    logic [15:0] normal_color;
    logic [15:0] notify_color;
    logic [15:0] alert_color;
  } cfg_t;

  typedef struct packed {
    logic [15:0] bar_color;
    logic [1:0]  cur_status;
    logic        shown;
    logic        redraw;
  } result_t;

  // floor(x / 255), exact for x below 65280 (products here stay at or below 64260)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

### design/scba_fade.sv
`timescale 1ns / 1ps

// Scales an RGB565 color by opa/255 on 8-bit channels.
module scba_fade (
  input  logic [15:0] color_i,
  input  logic [7:0]  opa_i,
  output logic [15:0] color_o
);

  logic [15:0] r_prod, g_prod, b_prod;
  logic [7:0]  r_q8, g_q8, b_q8;

  always_comb begin
    r_prod = {color_i[15:11], 3'b000} * opa_i;
    g_prod = {color_i[10:5], 2'b00} * opa_i;
    b_prod = {color_i[4:0], 3'b000} * opa_i;
    r_q8   = scba_pkg::div255(r_prod);
    g_q8   = scba_pkg::div255(g_prod);
    b_q8   = scba_pkg::div255(b_prod);
    if (opa_i == scba_pkg::OPA_HIGH) begin
      color_o = color_i;
    end else begin
      color_o = {r_q8[7:3], g_q8[7:2], b_q8[7:3]};
    end
  end

endmodule

### design/scba_core.sv
`timescale 1ns / 1ps

// Status and animation state; one item is applied per enabled cycle.
module scba_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [2:0]           op_i,
  input  logic [1:0]           new_status_i,
  input  scba_pkg::cfg_t       cfg_i,
  output scba_pkg::result_t    res_o
);

  logic [1:0]  status_q, status_d;
  logic        vis_q, vis_d;
  logic        anim_q, anim_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  opa_q, opa_d;
  logic        rising_q, rising_d;
  logic [15:0] color_q, color_d;

  logic [15:0] cnt_inc;
  logic [2:0]  phase_inc;
  logic [8:0]  opa_sum;
  logic [7:0]  opa_step;
  logic        rising_step;
  logic [7:0]  fade_opa;
  logic [15:0] fade_color;
  logic [15:0] before_color, after_color;

  // Next opacity of a breathing step, bounced between the limits
  always_comb begin
    if (rising_q) begin
      opa_sum = {1'b0, opa_q} + {1'b0, scba_pkg::OPA_STEP};
    end else if (opa_q > scba_pkg::OPA_STEP) begin
      opa_sum = {1'b0, opa_q} - {1'b0, scba_pkg::OPA_STEP};
    end else begin
      opa_sum = 9'd0;
    end
    opa_step    = opa_sum[7:0];
    rising_step = rising_q;
    if (opa_sum >= {1'b0, scba_pkg::OPA_HIGH}) begin
      opa_step    = scba_pkg::OPA_HIGH;
      rising_step = 1'b0;
    end
    if (opa_sum <= {1'b0, scba_pkg::OPA_LOW}) begin
      opa_step    = scba_pkg::OPA_LOW;
      rising_step = 1'b1;
    end
  end

  assign fade_opa = (op_i == scba_pkg::OP_SET) ? scba_pkg::OPA_LOW : opa_step;

  scba_fade u_fade (
    .color_i (cfg_i.alert_color),
    .opa_i   (fade_opa),
    .color_o (fade_color)
  );

  assign cnt_inc   = cnt_q + 16'd1;
  assign phase_inc = phase_q + 3'd1;

  always_comb begin
    status_d = status_q;
    vis_d    = vis_q;
    anim_d   = anim_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    opa_d    = opa_q;
    rising_d = rising_q;
    color_d  = color_q;
    case (op_i)
      scba_pkg::OP_TICK: begin
        if (anim_q) begin
          cnt_d = cnt_inc;
          if (status_q == scba_pkg::ST_NOTIFY) begin
            if (cnt_inc >= cfg_i.blink_ticks) begin
              cnt_d = 16'd0;
              if (phase_inc < scba_pkg::BLINK_PHASES) begin
                phase_d = phase_inc;
                if (vis_q) begin
                  color_d = phase_inc[0] ? cfg_i.notify_color : 16'd0;
                end
              end else begin
                phase_d = 3'd0;
                anim_d  = 1'b0;
                if (vis_q) begin
                  color_d = cfg_i.notify_color;
                end
              end
            end
          end else if (status_q == scba_pkg::ST_ALERT) begin
            if (cnt_inc >= cfg_i.breath_ticks) begin
              cnt_d    = 16'd0;
              opa_d    = opa_step;
              rising_d = rising_step;
              if (vis_q) begin
                color_d = fade_color;
              end
            end
          end else begin
            anim_d = 1'b0;
          end
        end
      end
      scba_pkg::OP_SET: begin
        if (new_status_i != status_q) begin
          anim_d   = 1'b0;
          cnt_d    = 16'd0;
          status_d = new_status_i;
          case (new_status_i)
            scba_pkg::ST_NORMAL: begin
              if (vis_q) color_d = cfg_i.normal_color;
            end
            scba_pkg::ST_NOTIFY: begin
              phase_d = 3'd0;
              anim_d  = 1'b1;
              if (vis_q) color_d = 16'd0;
            end
            scba_pkg::ST_ALERT: begin
              opa_d    = scba_pkg::OPA_LOW;
              rising_d = 1'b1;
              anim_d   = 1'b1;
              if (vis_q) color_d = fade_color;
            end
            default: begin
              // sleep: blank, then hide
              if (vis_q) color_d = 16'd0;
              vis_d = 1'b0;
            end
          endcase
        end
      end
      scba_pkg::OP_ACK: begin
        if (status_q == scba_pkg::ST_ALERT) begin
          anim_d   = 1'b0;
          cnt_d    = 16'd0;
          status_d = scba_pkg::ST_NORMAL;
          if (vis_q) color_d = cfg_i.normal_color;
        end
      end
      scba_pkg::OP_HIDE: begin
        anim_d = 1'b0;
        cnt_d  = 16'd0;
        if (vis_q) color_d = 16'd0;
        vis_d  = 1'b0;
      end
      scba_pkg::OP_SHOW: begin
        anim_d   = 1'b0;
        cnt_d    = 16'd0;
        vis_d    = 1'b1;
        status_d = scba_pkg::ST_NORMAL;
        color_d  = cfg_i.normal_color;
      end
      default: begin
        // unknown op: no change
      end
    endcase
  end

  assign before_color = vis_q ? color_q : 16'd0;
  assign after_color  = vis_d ? color_d : 16'd0;

  always_comb begin
    res_o.bar_color  = after_color;
    res_o.cur_status = status_d;
    res_o.shown      = vis_d;
    res_o.redraw     = (after_color != before_color);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= scba_pkg::ST_NORMAL;
      vis_q    <= 1'b1;
      anim_q   <= 1'b0;
      phase_q  <= 3'd0;
      cnt_q    <= 16'd0;
      opa_q    <= scba_pkg::OPA_LOW;
      rising_q <= 1'b1;
      color_q  <= scba_pkg::NORMAL_COLOR_RST;
    end else if (en_i) begin
      status_q <= status_d;
      vis_q    <= vis_d;
      anim_q   <= anim_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      opa_q    <= opa_d;
      rising_q <= rising_d;
      color_q  <= color_d;
    end
  end

endmodule

### design/status_color_bar_animator.sv
`timescale 1ns / 1ps
// An accepted item waits in the input register until the core applies it; its
//   result is then held in the result register until it is taken.
// Throughput: one item per cycle unless the result stalls; update is one pass.
// Reset (rst_ni low, async): registers return to their defaults, status normal,
//   bar visible in the normal color, opacity 30, both pipeline slots empty.

module status_color_bar_animator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [1:0]  new_status_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] bar_color_o,
  output logic [1:0]  cur_status_o,
  output logic        shown_o,
  output logic        redraw_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  scba_pkg::cfg_t    cfg_q;
  scba_pkg::result_t res_d;
  scba_pkg::result_t res_q;

  // Input register: holds one item until the core applies it
  logic       s1_valid_q;
  logic [2:0] s1_op_q;
  logic [1:0] s1_status_q;
  logic       out_valid_q;
  logic       advance;
  logic       in_fire;

  // The core applies the held item whenever the result slot is free or
  // being drained this cycle, so items flow at one per cycle.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= op_i;
      s1_status_q <= new_status_i;
    end
  end

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_ticks  <= scba_pkg::BLINK_TICKS_RST;
      cfg_q.breath_ticks <= scba_pkg::BREATH_TICKS_RST;
      cfg_q.normal_color <= scba_pkg::NORMAL_COLOR_RST;
      cfg_q.notify_color <= scba_pkg::NOTIFY_COLOR_RST;
      cfg_q.alert_color  <= scba_pkg::ALERT_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scba_pkg::CFG_BLINK_TICKS:  cfg_q.blink_ticks  <= cfg_wdata_i;
        scba_pkg::CFG_BREATH_TICKS: cfg_q.breath_ticks <= cfg_wdata_i;
        scba_pkg::CFG_NORMAL_COLOR: cfg_q.normal_color <= cfg_wdata_i;
        scba_pkg::CFG_NOTIFY_COLOR: cfg_q.notify_color <= cfg_wdata_i;
        scba_pkg::CFG_ALERT_COLOR:  cfg_q.alert_color  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Status/animation state and the per-item next-state logic
  scba_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .op_i         (s1_op_q),
    .new_status_i (s1_status_q),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bar_color_o  = res_q.bar_color;
  assign cur_status_o = res_q.cur_status;
  assign shown_o      = res_q.shown;
  assign redraw_o     = res_q.redraw;

endmodule

### design/scba_checker.sv
`timescale 1ns / 1ps
`include "status_color_bar_animator_assert.svh"

// Port-level checks on the animator.
module scba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] bar_color_o,
  input logic [1:0]  cur_status_o,
  input logic        shown_o,
  input logic        redraw_o
);

  `SCBA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(bar_color_o) && $stable(cur_status_o) && $stable(shown_o) && $stable(redraw_o), "stalled result changed")
  `SCBA_ASSERT_IMPL(a_hidden_black, out_valid_o && !shown_o, bar_color_o == 16'd0, "hidden bar not black")
  `SCBA_ASSERT_IMPL(a_sleep_hidden, out_valid_o && (cur_status_o == scba_pkg::ST_SLEEP), !shown_o, "sleep with bar shown")
  `SCBA_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with no result pending")

endmodule

bind status_color_bar_animator scba_checker u_scba_checker (.*);
